/* hdl/mpwd_pkg.sv */
// Package for the Manchester pulse width decoder.
// Holds field widths, the action and register codes and the shared structs.
// No dependencies.
`default_nettype none

package mpwd_pkg;

  localparam int unsigned WidthW  = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [ActionW-1:0] {
    ACT_START   = 2'd0,
    ACT_PULSE   = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  localparam logic [CfgIdxW-1:0] REG_HALF_MIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HALF_MAX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FULL_MIN = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FULL_MAX = 2'd3;

  localparam logic [WidthW-1:0] HalfMinReset = 16'd333;
  localparam logic [WidthW-1:0] HalfMaxReset = 16'd500;
  localparam logic [WidthW-1:0] FullMinReset = 16'd667;
  localparam logic [WidthW-1:0] FullMaxReset = 16'd1000;

  typedef struct packed {
    logic [WidthW-1:0] half_min;
    logic [WidthW-1:0] half_max;
    logic [WidthW-1:0] full_min;
    logic [WidthW-1:0] full_max;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0]  frame_word;
    logic [CountW-1:0] bit_count;
    logic              frame_valid;
  } result_t;

  typedef struct packed {
    logic    fire;
    logic    emit;
  } step_ctl_t;

endpackage

`default_nettype wire

/* hdl/mpwd_in_if.sv */
// Input channel of the Manchester pulse width decoder: valid, ready, payload.
// Depends on mpwd_pkg.
`default_nettype none

interface mpwd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mpwd_pkg::ActionW-1:0] action;
  logic [mpwd_pkg::WidthW-1:0]  pulse_width;

  modport source (output valid, output action, output pulse_width, input ready);
  modport sink (input valid, input action, input pulse_width, output ready);
endinterface

`default_nettype wire

/* hdl/mpwd_out_if.sv */
// Result channel of the Manchester pulse width decoder: valid, ready, payload.
// Depends on mpwd_pkg.
`default_nettype none

interface mpwd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpwd_pkg::WordW-1:0]  frame_word;
  logic [mpwd_pkg::CountW-1:0] bit_count;
  logic                        frame_valid;

  modport source (output valid, output frame_word, output bit_count, output frame_valid,
                  input ready);
  modport sink (input valid, input frame_word, input bit_count, input frame_valid,
                output ready);
endinterface

`default_nettype wire

/* hdl/mpwd_frame.sv */
// Frame state machine: classes each pulse and builds word, count and valid flag.
// Depends on mpwd_pkg.
`default_nettype none

module mpwd_frame (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mpwd_pkg::cfg_t               cfg,
  input  wire logic [mpwd_pkg::ActionW-1:0] action,
  input  wire logic [mpwd_pkg::WidthW-1:0]  pulse_width,
  input  wire logic                         fire,
  output logic                              emit,
  output mpwd_pkg::result_t                 result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_HALF,
    PH_BOUNDARY,
    PH_INVALID
  } phase_t;

  phase_t                      phase, phase_next;
  logic [mpwd_pkg::WordW-1:0]  shift_word, shift_word_next;
  logic [mpwd_pkg::CountW-1:0] count, count_next;
  logic                        previous_bit, previous_bit_next;
  logic                        good, good_next;
  logic                        is_half, is_full;
  logic [mpwd_pkg::CountW-1:0] count_inc;

  assign is_half = (pulse_width >= cfg.half_min) && (pulse_width <= cfg.half_max);
  assign is_full = (pulse_width >= cfg.full_min) && (pulse_width <= cfg.full_max);
  assign count_inc = (count == mpwd_pkg::CountMax) ? count : count + 1'b1;

  assign emit = (action == mpwd_pkg::ACT_TIMEOUT) && (phase != PH_IDLE);
  assign result = '{frame_word: shift_word, bit_count: count, frame_valid: good};

  always_comb begin
    phase_next        = phase;
    shift_word_next   = shift_word;
    count_next        = count;
    previous_bit_next = previous_bit;
    good_next         = good;
    unique case (action)
      mpwd_pkg::ACT_START: begin
        shift_word_next = '0;
        count_next      = '0;
        good_next       = 1'b1;
        phase_next      = PH_START;
      end
      mpwd_pkg::ACT_PULSE: begin
        unique case (phase)
          PH_START: begin
            if (is_half) begin
              previous_bit_next = 1'b1;
              phase_next        = PH_HALF;
            end else begin
              phase_next = PH_INVALID;
              good_next  = 1'b0;
            end
          end
          PH_HALF: begin
            priority if (is_half) begin
              phase_next = PH_BOUNDARY;
            end else if (is_full) begin
              previous_bit_next = ~previous_bit;
              shift_word_next   = {shift_word[mpwd_pkg::WordW-2:0], ~previous_bit};
              count_next        = count_inc;
            end else begin
              phase_next = PH_INVALID;
              good_next  = 1'b0;
            end
          end
          PH_BOUNDARY: begin
            if (is_half) begin
              shift_word_next = {shift_word[mpwd_pkg::WordW-2:0], previous_bit};
              count_next      = count_inc;
              phase_next      = PH_HALF;
            end else begin
              phase_next = PH_INVALID;
              good_next  = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      mpwd_pkg::ACT_TIMEOUT: begin
        phase_next = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      shift_word   <= '0;
      count        <= '0;
      previous_bit <= 1'b0;
      good         <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      shift_word   <= shift_word_next;
      count        <= count_next;
      previous_bit <= previous_bit_next;
      good         <= good_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/mpwd_out.sv */
// Result register of the Manchester pulse width decoder.
// Depends on mpwd_pkg and mpwd_out_if.
`default_nettype none

module mpwd_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpwd_pkg::step_ctl_t ctl,
  input  wire mpwd_pkg::result_t  result,
  output logic                    space,
  mpwd_out_if.source              frame_out
);

  logic              valid;
  mpwd_pkg::result_t held;

  assign space = !valid || frame_out.ready;

  assign frame_out.valid       = valid;
  assign frame_out.frame_word  = held.frame_word;
  assign frame_out.bit_count   = held.bit_count;
  assign frame_out.frame_valid = held.frame_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.fire && ctl.emit) begin
      valid <= 1'b1;
    end else if (frame_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.emit) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

/* hdl/manchester_pulse_width_decoder.sv */
// Manchester pulse width decoder, top level.
// Depends on mpwd_pkg, mpwd_in_if, mpwd_out_if, mpwd_frame and mpwd_out.
//
// Usage:
//   pulse_in carries one item per handshake: an action (start, pulse, timeout)
//   and a pulse width in timer ticks. frame_out carries one result per
//   timeout that closes an open frame: word, bit count and valid flag.
//   The cfg port writes the four tick window registers (half min/max,
//   full min/max); write only while no item is in flight.
//   An item waits in the input register; a timeout result passes from there
//   through the frame update into the result register that drives frame_out.
//   Throughput: one item per cycle while the result register has room, set by
//   the frame update between the input register and the result register.
//   Reset clears the windows to their defaults, the frame to idle and
//   drops any pending item or result.
//   When frame_out stalls, the result register holds; pulse_in keeps taking
//   items until a second timeout result would need the occupied register.
`default_nettype none

module manchester_pulse_width_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  mpwd_in_if.sink                           pulse_in,
  mpwd_out_if.source                        frame_out,
  input  wire logic                         cfg_we,
  input  wire logic [mpwd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [mpwd_pkg::WidthW-1:0]  cfg_data
);

  mpwd_pkg::cfg_t               cfg;
  logic                         item_valid;
  logic [mpwd_pkg::ActionW-1:0] item_action;
  logic [mpwd_pkg::WidthW-1:0]  item_width;
  logic                         emit;
  logic                         space;
  mpwd_pkg::result_t            result;
  mpwd_pkg::step_ctl_t          ctl;

  assign ctl.emit = emit;
  assign ctl.fire = item_valid && (!emit || space);
  assign pulse_in.ready = !item_valid || ctl.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_min <= mpwd_pkg::HalfMinReset;
      cfg.half_max <= mpwd_pkg::HalfMaxReset;
      cfg.full_min <= mpwd_pkg::FullMinReset;
      cfg.full_max <= mpwd_pkg::FullMaxReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpwd_pkg::REG_HALF_MIN: cfg.half_min <= cfg_data;
        mpwd_pkg::REG_HALF_MAX: cfg.half_max <= cfg_data;
        mpwd_pkg::REG_FULL_MIN: cfg.full_min <= cfg_data;
        mpwd_pkg::REG_FULL_MAX: cfg.full_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pulse_in.ready) begin
      item_valid <= pulse_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_in.ready && pulse_in.valid) begin
      item_action <= pulse_in.action;
      item_width  <= pulse_in.pulse_width;
    end
  end

  mpwd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .action      (item_action),
    .pulse_width (item_width),
    .fire        (ctl.fire),
    .emit        (emit),
    .result      (result)
  );

  mpwd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result    (result),
    .space     (space),
    .frame_out (frame_out)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for manchester_pulse_width_decoder: drives start, pulse
// and timeout items, predicts each reported frame and compares it field by field.
// Depends on mpwd_pkg, mpwd_in_if, mpwd_out_if and the decoder itself.

module tb_top;
  import mpwd_pkg::*;

  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;
  localparam int RandItems   = 1850;
  localparam int NumSettings = 8;

  typedef enum logic [2:0] {
    FP_IDLE, FP_START, FP_HALF, FP_BOUNDARY, FP_INVALID
  } frame_phase_t;

  class frame_tracker;
    cfg_t              win;
    frame_phase_t      phase;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              prev_bit;
    logic              good;
    result_t           frames_due[$];
    int                errors;
    int                items;
    int                frames;

    function new();
      win      = '{HalfMinReset, HalfMaxReset, FullMinReset, FullMaxReset};
      phase    = FP_IDLE;
      word     = '0;
      count    = '0;
      prev_bit = 1'b0;
      good     = 1'b0;
      errors   = 0;
      items    = 0;
      frames   = 0;
    endfunction

    function void set_window(logic [CfgIdxW-1:0] idx, logic [WidthW-1:0] v);
      case (idx)
        REG_HALF_MIN: win.half_min = v;
        REG_HALF_MAX: win.half_max = v;
        REG_FULL_MIN: win.full_min = v;
        REG_FULL_MAX: win.full_max = v;
        default: ;
      endcase
    endfunction

    function void shift_bit();
      word = {word[WordW-2:0], prev_bit};
      if (count != CountMax) count = count + 1'b1;
    endfunction

    function void drop_frame();
      phase = FP_INVALID;
      good  = 1'b0;
    endfunction

    function void note_item(logic [ActionW-1:0] act, logic [WidthW-1:0] w);
      logic    is_half;
      logic    is_full;
      result_t r;
      is_half = (w >= win.half_min) && (w <= win.half_max);
      is_full = (w >= win.full_min) && (w <= win.full_max);
      items++;
      case (act)
        ACT_START: begin
          word  = '0;
          count = '0;
          good  = 1'b1;
          phase = FP_START;
        end
        ACT_PULSE: begin
          case (phase)
            FP_START: begin
              if (is_half) begin
                prev_bit = 1'b1;
                phase    = FP_HALF;
              end else begin
                drop_frame();
              end
            end
            FP_HALF: begin
              if (is_half) begin
                phase = FP_BOUNDARY;
              end else if (is_full) begin
                prev_bit = ~prev_bit;
                shift_bit();
              end else begin
                drop_frame();
              end
            end
            FP_BOUNDARY: begin
              if (is_half) begin
                shift_bit();
                phase = FP_HALF;
              end else begin
                drop_frame();
              end
            end
            default: ;
          endcase
        end
        ACT_TIMEOUT: begin
          if (phase != FP_IDLE) begin
            r.frame_word  = word;
            r.bit_count   = count;
            r.frame_valid = good;
            frames_due.push_back(r);
            phase = FP_IDLE;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_frame(result_t got);
      result_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected frame word=%h count=%0d valid=%0b",
                         got.frame_word, got.bit_count, got.frame_valid));
        return;
      end
      want = frames_due.pop_front();
      frames++;
      if (got.frame_word !== want.frame_word)
        report($sformatf("frame_word got %h want %h", got.frame_word, want.frame_word));
      if (got.bit_count !== want.bit_count)
        report($sformatf("bit_count got %0d want %0d", got.bit_count, want.bit_count));
      if (got.frame_valid !== want.frame_valid)
        report($sformatf("frame_valid got %b want %b", got.frame_valid, want.frame_valid));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [WidthW-1:0]   cfg_data;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  rand_sent;
  bit                  random_part;
  frame_tracker        tracker;

  mpwd_in_if  pulse_ch ();
  mpwd_out_if frame_ch ();

  manchester_pulse_width_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .pulse_in  (pulse_ch),
    .frame_out (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    frame_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (!rst) begin
      if (pulse_ch.valid && pulse_ch.ready)
        tracker.note_item(pulse_ch.action, pulse_ch.pulse_width);
      if (frame_ch.valid && frame_ch.ready) begin
        got.frame_word  = frame_ch.frame_word;
        got.bit_count   = frame_ch.bit_count;
        got.frame_valid = frame_ch.frame_valid;
        tracker.check_frame(got);
      end
    end
  end

  function automatic cfg_t setting_at(int k);
    case (k)
      0: return '{16'd333, 16'd500, 16'd667, 16'd1000};
      1: return '{16'd0, 16'd0, 16'd0, 16'd0};
      2: return '{16'd0, 16'd65535, 16'd0, 16'd65535};
      3: return '{16'd100, 16'd200, 16'd201, 16'd400};
      4: return '{16'd500, 16'd300, 16'd65535, 16'd65535};
      5: return '{16'd300, 16'd700, 16'd600, 16'd1000};
      6: return '{16'd65534, 16'd65535, 16'd1, 16'd65533};
      default: return '{16'd10, 16'd20, 16'd100, 16'd50};
    endcase
  endfunction

  function automatic logic [WidthW-1:0] pick_width(logic [WidthW-1:0] lo,
                                                   logic [WidthW-1:0] hi);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return lo;
    if (pick < 8) return hi;
    if (pick == 8) return lo - 1'b1;
    if (pick == 9) return hi + 1'b1;
    if (lo > hi) return WidthW'($urandom);
    return WidthW'($urandom_range(hi, lo));
  endfunction

  task automatic send_item(logic [ActionW-1:0] act, logic [WidthW-1:0] w);
    int gap;
    gap = 0;
    if (rand_sent < RandItems / 3) begin
      send_idle_pct  = 33;
      recv_stall_pct = 86;
    end else if (rand_sent < 2 * RandItems / 3) begin
      send_idle_pct  = 86;
      recv_stall_pct = 33;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pulse_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulse_ch.valid       <= 1'b1;
    pulse_ch.action      <= act;
    pulse_ch.pulse_width <= w;
    do @(posedge clk); while (!pulse_ch.ready);
    if (random_part) rand_sent++;
  endtask

  task automatic send_pulse(logic [WidthW-1:0] lo, logic [WidthW-1:0] hi);
    if ($urandom_range(0, 99) == 0)
      send_item(ActionW'($urandom_range(0, 3)), WidthW'($urandom));
    if ($urandom_range(0, 99) == 0)
      send_item(ACT_PULSE, WidthW'($urandom));
    else
      send_item(ACT_PULSE, pick_width(lo, hi));
  endtask

  task automatic send_frame(int nbits);
    logic b;
    logic prev;
    send_item(ACT_START, WidthW'($urandom));
    send_pulse(tracker.win.half_min, tracker.win.half_max);
    prev = 1'b1;
    for (int i = 0; i < nbits; i++) begin
      b = $urandom_range(0, 1);
      if (b != prev) begin
        send_pulse(tracker.win.full_min, tracker.win.full_max);
      end else begin
        send_pulse(tracker.win.half_min, tracker.win.half_max);
        send_pulse(tracker.win.half_min, tracker.win.half_max);
      end
      prev = b;
    end
    if ($urandom_range(0, 9) != 0) send_item(ACT_TIMEOUT, WidthW'($urandom));
  endtask

  task automatic drain();
    pulse_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WidthW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.set_window(idx, v);
  endtask

  task automatic write_window(cfg_t c);
    write_reg(REG_HALF_MIN, c.half_min);
    write_reg(REG_HALF_MAX, c.half_max);
    write_reg(REG_FULL_MIN, c.full_min);
    write_reg(REG_FULL_MAX, c.full_max);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int setting_start;
    int wait_cycles;
    rst                  = 1'b1;
    pulse_ch.valid       = 1'b0;
    pulse_ch.action      = ACT_START;
    pulse_ch.pulse_width = '0;
    frame_ch.ready       = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_HALF_MIN;
    cfg_data             = '0;
    send_idle_pct        = 33;
    recv_stall_pct       = 86;
    rand_sent            = 0;
    random_part          = 1'b0;
    tracker              = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle, stray and empty frames at the reset windows
    send_item(ACT_TIMEOUT, 16'd0);
    send_item(ACT_PULSE, 16'd400);
    send_item(ACT_UNUSED, 16'hFFFF);
    send_item(ACT_START, 16'd0);
    send_item(ACT_TIMEOUT, 16'hFFFF);
    // window edges, then restart of an open frame
    send_item(ACT_START, 16'hFFFF);
    send_item(ACT_PULSE, 16'd333);
    send_item(ACT_PULSE, 16'd1000);
    send_item(ACT_PULSE, 16'd500);
    send_item(ACT_PULSE, 16'd500);
    send_item(ACT_PULSE, 16'd667);
    send_item(ACT_START, 16'd1);
    send_item(ACT_PULSE, 16'd400);
    send_item(ACT_TIMEOUT, 16'd0);
    // illegal widths, pulses after the frame went bad
    send_item(ACT_START, 16'd0);
    send_item(ACT_PULSE, 16'd0);
    send_item(ACT_PULSE, 16'd400);
    send_item(ACT_TIMEOUT, 16'd0);
    send_item(ACT_START, 16'd0);
    send_item(ACT_PULSE, 16'd400);
    send_item(ACT_PULSE, 16'hFFFF);
    send_item(ACT_TIMEOUT, 16'd0);
    send_item(ACT_START, 16'd0);
    send_item(ACT_PULSE, 16'd332);
    send_item(ACT_TIMEOUT, 16'd0);
    drain();

    random_part = 1'b1;
    for (int k = 0; k < NumSettings; k++) begin
      write_window(setting_at(k));
      setting_start = rand_sent;
      if (k == 0) send_frame(270);
      while (rand_sent - setting_start < RandItems / NumSettings) begin
        if ($urandom_range(0, 19) == 0) send_frame($urandom_range(35, 64));
        else send_frame($urandom_range(0, 34));
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    wait_cycles = 0;
    while (tracker.frames_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (6) @(posedge clk);
    if (tracker.frames_due.size() != 0)
      tracker.report($sformatf("%0d frames never arrived", tracker.frames_due.size()));

    $display("covered %0d items and %0d frames over %0d window settings",
             tracker.items, tracker.frames, NumSettings);
    $display("with sender idle 33/86/0 and receiver stall 86/33/0 percent");
    if (tracker.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mpwd_pkg.sv
hdl/mpwd_in_if.sv
hdl/mpwd_out_if.sv
hdl/mpwd_frame.sv
hdl/mpwd_out.sv
hdl/manchester_pulse_width_decoder.sv
bench/tb_top.sv
